// ----- sv/orb_pkg.sv -----
// ----------------------------------------------------------------------------
// orb_pkg
// shared types, constants and index helpers for the overwrite ring buffer
// ----------------------------------------------------------------------------
package orb_pkg;

  localparam int DEPTH      = 32;
  localparam int ENTRY_BITS = 32;
  localparam int IDX_BITS   = $clog2(DEPTH);
  localparam int CAP_BITS   = $clog2(DEPTH + 1);
  localparam int CFG_BITS   = 6;
  localparam int OP_BITS    = 2;

  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CAP_BITS-1:0]   cap_t;
  typedef logic [ENTRY_BITS-1:0] entry_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic append;
    logic remove;
    logic list_start;
    logic rd_advance;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic rd_last;
    logic out_busy;
  } status_t;

  // clamp the raw register value to 1..DEPTH
  function automatic cap_t cap_limit(input logic [CFG_BITS-1:0] raw);
    cap_t res;
    if (raw == '0) begin
      res = cap_t'(1);
    end else if (int'(raw) > DEPTH) begin
      res = cap_t'(DEPTH);
    end else begin
      res = cap_t'(raw);
    end
    return res;
  endfunction

  function automatic idx_t wrap_next(input idx_t i, input cap_t cap);
    cap_t nxt;
    nxt = cap_t'(i) + cap_t'(1);
    return (nxt >= cap) ? '0 : nxt[IDX_BITS-1:0];
  endfunction

endpackage

// ----- sv/orb_datapath.sv -----
// ----------------------------------------------------------------------------
// orb_datapath
// slot memory, head and tail pointers, list read pointer and output register
// ----------------------------------------------------------------------------
module orb_datapath
  import orb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [ENTRY_BITS-1:0] payload,
  input  logic                  cfg_wen,
  input  logic [CFG_BITS-1:0]   cfg_wdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [ENTRY_BITS-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  entry_t mem [DEPTH];
  entry_t rd_data;

  logic [CFG_BITS-1:0] capacity;
  cap_t cap;
  idx_t head, head_next;
  idx_t tail, tail_next;
  logic empty, empty_next;
  idx_t rd_ptr;

  logic wr_en;
  idx_t wr_addr;
  idx_t head_inc, tail_inc;
  logic full;

  assign cap      = cap_limit(capacity);
  assign head_inc = wrap_next(head, cap);
  assign tail_inc = wrap_next(tail, cap);
  assign full     = (tail_inc == head);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty;
    wr_en      = 1'b0;
    wr_addr    = tail_inc;
    if (cmd.append) begin
      wr_en = 1'b1;
      if (empty) begin
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b0;
        wr_addr    = '0;
      end else if (full) begin
        // overwrite oldest
        wr_addr   = head;
        tail_next = head;
        head_next = head_inc;
      end else begin
        tail_next = tail_inc;
        wr_addr   = tail_inc;
      end
    end else if (cmd.remove && !empty) begin
      if (head == tail) begin
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b1;
      end else begin
        head_next = head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CFG_BITS'(DEPTH);
      head     <= '0;
      tail     <= '0;
      empty    <= 1'b1;
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
      head     <= '0;
      tail     <= '0;
      empty    <= 1'b1;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= payload;
    end
    rd_data <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.list_start) begin
      rd_ptr <= head;
    end else if (cmd.rd_advance) begin
      rd_ptr <= wrap_next(rd_ptr, cap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_axis_tdata <= rd_data;
      m_axis_tlast <= (rd_ptr == tail);
    end
  end

  assign status.empty    = empty;
  assign status.rd_last  = (rd_ptr == tail);
  assign status.out_busy = m_axis_tvalid && !m_axis_tready;

endmodule

// ----- sv/orb_ctrl.sv -----
// ----------------------------------------------------------------------------
// orb_ctrl
// op decode and list sequencing for the overwrite ring buffer
// ----------------------------------------------------------------------------
module orb_ctrl
  import orb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [OP_BITS-1:0] s_axis_tuser,
  input  status_t            status,
  output cmd_t               cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(s_axis_tuser))
            OP_APPEND: cmd.append = 1'b1;
            OP_REMOVE: cmd.remove = 1'b1;
            OP_LIST: begin
              if (!status.empty) begin
                cmd.list_start = 1'b1;
                state_next     = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          if (status.rd_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.rd_advance = 1'b1;
            state_next     = ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/overwrite_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// overwrite_ring_buffer
// ring buffer that overwrites its oldest word when full, with list readout
// ----------------------------------------------------------------------------
// append and remove: accepted back to back
// list: input stalls while the buffer holds words; each held word gets a slot memory
//   read, then an output register load, which waits while the output is stalled
// reset (rst, synchronous): buffer empty, capacity 32, output idle; slot
//   contents are not cleared
module overwrite_ring_buffer
  import orb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_BITS-1:0]   cfg_wdata,     // capacity
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ENTRY_BITS-1:0] s_axis_tdata,  // payload
  input  logic [OP_BITS-1:0]    s_axis_tuser,  // op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [ENTRY_BITS-1:0] m_axis_tdata,  // entry
  output logic                  m_axis_tlast
);

  cmd_t    cmd;
  status_t status;

  orb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .status        (status),
    .cmd           (cmd)
  );

  orb_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .payload       (s_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- sv/orb_checker.sv -----
// ----------------------------------------------------------------------------
// orb_checker
// port level checks for the overwrite ring buffer
// ----------------------------------------------------------------------------
module orb_checker
  import orb_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_wen,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [OP_BITS-1:0]    s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [ENTRY_BITS-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // words only come out of a list run, which stalls input
  a_out_in_list: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("output word outside a list run");

  // a capacity write empties the buffer, so a list right after gives nothing
  a_cfg_empties: assert property (@(posedge clk) disable iff (rst)
    cfg_wen ##1 (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LIST)
      |=> s_axis_tready)
    else $error("list after capacity write did not finish at once");

  // nothing pending after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

endmodule

bind overwrite_ring_buffer orb_checker u_orb_checker (.*);
